@@ rtl/euler_to_rotation_matrix_core_macros.svh @@
// Assertion macros for the Euler rotation matrix core.
`ifndef EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// Check outside reset.
`define E2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define E2R_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/e2r_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_pkg
// Fixed-point constants and helpers for the Euler rotation matrix core.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int ATAN_ENTRIES = 24;

  // Q30 constants
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_TWO_PI  = 34'sd6746518852;
  localparam logic signed [32:0] Q30_HALF_PI = 33'sd1686629713;
  localparam logic signed [31:0] Q30_GAIN    = 32'sd652032874;

  typedef logic signed [31:0] q30_t;

  // atan(2^-i) in Q30, truncated
  function automatic q30_t atan_q30(input logic [4:0] idx);
    q30_t v;
    case (idx)
      5'd0:    v = 32'sd843314856;
      5'd1:    v = 32'sd497837829;
      5'd2:    v = 32'sd263043836;
      5'd3:    v = 32'sd133525158;
      5'd4:    v = 32'sd67021686;
      5'd5:    v = 32'sd33543515;
      5'd6:    v = 32'sd16775850;
      5'd7:    v = 32'sd8388437;
      5'd8:    v = 32'sd4194282;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048575;
      5'd11:   v = 32'sd524287;
      5'd12:   v = 32'sd262143;
      5'd13:   v = 32'sd131071;
      5'd14:   v = 32'sd65535;
      5'd15:   v = 32'sd32767;
      5'd16:   v = 32'sd16383;
      5'd17:   v = 32'sd8191;
      5'd18:   v = 32'sd4095;
      5'd19:   v = 32'sd2047;
      5'd20:   v = 32'sd1023;
      5'd21:   v = 32'sd511;
      5'd22:   v = 32'sd255;
      5'd23:   v = 32'sd127;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Q30 product, rounded half up
  function automatic q30_t mulq(input q30_t p, input q30_t q);
    logic signed [63:0] prod;
    prod = (p * q) + 64'sd536870912;
    return prod[61:30];
  endfunction

endpackage

@@ rtl/euler_to_rotation_matrix_core.sv @@
`timescale 1ns / 1ps
// Pipeline: wrap, fold and seed, CORDIC, first product, second product, sum and output stages.
// Throughput: one word per cycle while out_tready holds no stall; one CORDIC iteration per pipeline stage.
// Each stage holds its word while the stage after it is full and stalled.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// Heading/attitude/bank angles to 3x3 rotation matrix via pipelined CORDIC.
// ----------------------------------------------------------------------------
`include "euler_to_rotation_matrix_core_macros.svh"

module euler_to_rotation_matrix_core
  import e2r_pkg::*;
#(
  parameter int SINCOS_ITERATIONS = 16,
  parameter int OUT_FRACTION_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // heading_angle, attitude_angle, bank_angle
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
  // col2_row0, col2_row1, col2_row2
  output logic [143:0] out_tdata
);

  localparam int IT      = (SINCOS_ITERATIONS < ATAN_ENTRIES) ? SINCOS_ITERATIONS
                                                              : ATAN_ENTRIES;
  localparam int ST_M1   = 2 + IT;
  localparam int ST_M2   = 3 + IT;
  localparam int ST_SUM  = 4 + IT;
  localparam int ST_OUT  = 5 + IT;
  localparam int NST     = 6 + IT;
  localparam int RS      = 30 - OUT_FRACTION_BITS;
  localparam logic signed [33:0] HALF =
    (RS > 0) ? (34'sd1 <<< ((RS > 0) ? RS - 1 : 0)) : 34'sd0;
  localparam logic signed [33:0] LIM = 34'sd1 <<< OUT_FRACTION_BITS;

  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;

  assign rdy[NST] = out_tready;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage 0: wrap into [-pi, pi]
  logic signed [32:0] red_r [3];
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [33:0] a;
        a = {in_tdata[16*j +: 16], 18'b0};
        if (a > Q30_PI)       red_r[j] <= 33'(a - Q30_TWO_PI);
        else if (a < -Q30_PI) red_r[j] <= 33'(a + Q30_TWO_PI);
        else                  red_r[j] <= 33'(a);
      end
    end
  end

  // Stage 1: fold into [-pi/2, pi/2] and seed CORDIC
  q30_t cx_r [IT+1][3];
  q30_t cy_r [IT+1][3];
  q30_t cz_r [IT+1][3];
  logic [2:0] neg_r [IT+1];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int j = 0; j < 3; j++) begin
        cx_r[0][j] <= Q30_GAIN;
        cy_r[0][j] <= '0;
        if (red_r[j] > 33'(Q30_HALF_PI)) begin
          cz_r[0][j]  <= 32'(red_r[j] - 33'(Q30_PI));
          neg_r[0][j] <= 1'b1;
        end else if (red_r[j] < -33'(Q30_HALF_PI)) begin
          cz_r[0][j]  <= 32'(red_r[j] + 33'(Q30_PI));
          neg_r[0][j] <= 1'b1;
        end else begin
          cz_r[0][j]  <= 32'(red_r[j]);
          neg_r[0][j] <= 1'b0;
        end
      end
    end
  end

  for (genvar i = 0; i < IT; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rdy[2+i]) begin
        neg_r[i+1] <= neg_r[i];
        for (int j = 0; j < 3; j++) begin
          if (!cz_r[i][j][31]) begin
            cx_r[i+1][j] <= cx_r[i][j] - (cy_r[i][j] >>> i);
            cy_r[i+1][j] <= cy_r[i][j] + (cx_r[i][j] >>> i);
            cz_r[i+1][j] <= cz_r[i][j] - atan_q30(5'(i));
          end else begin
            cx_r[i+1][j] <= cx_r[i][j] + (cy_r[i][j] >>> i);
            cy_r[i+1][j] <= cy_r[i][j] - (cx_r[i][j] >>> i);
            cz_r[i+1][j] <= cz_r[i][j] + atan_q30(5'(i));
          end
        end
      end
    end
  end

  // apply the fold sign
  q30_t sh, ch, sa, ca, sb, cb;
  assign sh = neg_r[IT][0] ? -cy_r[IT][0] : cy_r[IT][0];
  assign ch = neg_r[IT][0] ? -cx_r[IT][0] : cx_r[IT][0];
  assign sa = neg_r[IT][1] ? -cy_r[IT][1] : cy_r[IT][1];
  assign ca = neg_r[IT][1] ? -cx_r[IT][1] : cx_r[IT][1];
  assign sb = neg_r[IT][2] ? -cy_r[IT][2] : cy_r[IT][2];
  assign cb = neg_r[IT][2] ? -cx_r[IT][2] : cx_r[IT][2];

  // First product stage
  q30_t chca_r, shca_r, cacb_r, shsb_r, chsb_r, shcb_r, casb_r, chcb_r;
  q30_t csa_r, ssa_r, sa_r, sb_r, cb_r;
  always_ff @(posedge clk) begin
    if (rdy[ST_M1]) begin
      chca_r <= mulq(ch, ca);
      shca_r <= mulq(sh, ca);
      cacb_r <= mulq(ca, cb);
      shsb_r <= mulq(sh, sb);
      chsb_r <= mulq(ch, sb);
      shcb_r <= mulq(sh, cb);
      casb_r <= mulq(ca, sb);
      chcb_r <= mulq(ch, cb);
      csa_r  <= mulq(ch, sa);
      ssa_r  <= mulq(sh, sa);
      sa_r   <= sa;
      sb_r   <= sb;
      cb_r   <= cb;
    end
  end

  // Second product stage
  q30_t t1_r, t2_r, t3_r, t4_r;
  q30_t chca2_r, shca2_r, cacb2_r, shsb2_r, chsb2_r, shcb2_r, casb2_r, chcb2_r, sa2_r;
  always_ff @(posedge clk) begin
    if (rdy[ST_M2]) begin
      t1_r    <= mulq(csa_r, cb_r);
      t2_r    <= mulq(ssa_r, cb_r);
      t3_r    <= mulq(csa_r, sb_r);
      t4_r    <= mulq(ssa_r, sb_r);
      chca2_r <= chca_r;
      shca2_r <= shca_r;
      cacb2_r <= cacb_r;
      shsb2_r <= shsb_r;
      chsb2_r <= chsb_r;
      shcb2_r <= shcb_r;
      casb2_r <= casb_r;
      chcb2_r <= chcb_r;
      sa2_r   <= sa_r;
    end
  end

  // Sums
  logic signed [32:0] ent_r [9];
  always_ff @(posedge clk) begin
    if (rdy[ST_SUM]) begin
      ent_r[0] <= 33'(chca2_r);
      ent_r[1] <= 33'(sa2_r);
      ent_r[2] <= -33'(shca2_r);
      ent_r[3] <= 33'(shsb2_r) - 33'(t1_r);
      ent_r[4] <= 33'(cacb2_r);
      ent_r[5] <= 33'(t2_r) + 33'(chsb2_r);
      ent_r[6] <= 33'(t3_r) + 33'(shcb2_r);
      ent_r[7] <= -33'(casb2_r);
      ent_r[8] <= 33'(chcb2_r) - 33'(t4_r);
    end
  end

  // Round, saturate, output register
  logic [143:0] out_nxt;
  logic [143:0] out_r;
  always_comb begin
    for (int j = 0; j < 9; j++) begin
      logic signed [33:0] rnd;
      rnd = (34'(ent_r[j]) + HALF) >>> RS;
      if (rnd > LIM)       rnd = LIM;
      else if (rnd < -LIM) rnd = -LIM;
      out_nxt[16*j +: 16] = rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata = out_r;

  `E2R_ASSERT(a_empty_out_ready, !out_tvalid |-> in_tready, "input blocked with empty output")
  `E2R_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "output valid right after reset")
  `E2R_ASSERT(a_sat_range, (out_tvalid && OUT_FRACTION_BITS <= 14) |-> ($signed(out_tdata[15:0]) <= 16'(LIM) && $signed(out_tdata[15:0]) >= -16'(LIM)), "entry beyond saturation limit")

endmodule
